// ===== sv/fdc_pkg.sv =====
`timescale 1ns / 1ps

package fdc_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int COEFF_WIDTH     = 16;
  localparam int INDEX_WIDTH     = 5;
  localparam int TAP_COUNT_WIDTH = 6;
  localparam int TAPS_DEFAULT    = 32;
  localparam int ACC_WIDTH       = 40;
  localparam int ROUND_SHIFT     = 16;

  localparam logic [TAP_COUNT_WIDTH-1:0] TAP_COUNT_RESET = TAP_COUNT_WIDTH'(32);

  localparam logic signed [ACC_WIDTH-1:0] ROUND_BIAS = ACC_WIDTH'(1) << (ROUND_SHIFT - 1);
  localparam logic signed [ACC_WIDTH-1:0] SAT_HI     = ACC_WIDTH'(2**(SAMPLE_WIDTH-1) - 1);
  localparam logic signed [ACC_WIDTH-1:0] SAT_LO     = ~SAT_HI;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  typedef struct packed {
    logic                           opcode;
    logic signed [SAMPLE_WIDTH-1:0] sample_value;
    logic        [INDEX_WIDTH-1:0]  coeff_index;
    logic signed [COEFF_WIDTH-1:0]  coeff_value;
    logic                           last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] filtered_sample;
    logic                           saturated;
    logic                           final_result;
  } out_item_t;

endpackage

// ===== sv/fir_direct_convolution.sv =====
// Direct-form FIR filter with one shared multiply-accumulate. A load beat (opcode 1) writes one
// coefficient into the tap memory. A sample beat (opcode 0) enters a circular delay line and the
// block then walks the L active taps (L = tap_count, 0 taken as 1, capped at TAPS), one history
// read, one coefficient read and one multiply per cycle. A sample marked last adds L - 1 flush
// passes with zero input. The single multiplier and the single read port of each memory set the
// pace of the tap walk. Results pass through a one-entry output register, so the next beat is
// taken while a result still waits; a pass only stalls when it must emit and that register is
// still full. The first L outputs of a stream are dropped, and the last emitted result of a flush
// carries final_result. The delay line is cleared by a fill count, with no sweep.
`timescale 1ns / 1ps

module fir_direct_convolution
  import fdc_pkg::*;
#(
  parameter int TAPS = TAPS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  in_item_t                   in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output out_item_t                  out_data,
  input  logic                       cfg_wr_en,
  input  logic [TAP_COUNT_WIDTH-1:0] cfg_wr_data
);

  localparam int AW = $clog2(TAPS);
  localparam int LW = $clog2(TAPS + 1);
  localparam int PW = SAMPLE_WIDTH + COEFF_WIDTH;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TAPS - 1);
  localparam logic [LW-1:0] TAPS_L    = LW'(TAPS);
  localparam logic [TAP_COUNT_WIDTH:0] TAPS_C = (TAP_COUNT_WIDTH + 1)'(TAPS);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MAC    = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                  state;
  logic [TAP_COUNT_WIDTH-1:0]  tap_count;
  logic [AW-1:0]               head;
  logic [AW-1:0]               rd_ptr;
  logic [LW-1:0]               fill;
  logic [LW-1:0]               mac_cnt;
  logic [LW-1:0]               flush_cnt;
  logic [LW-1:0]               out_count;
  logic                        last_q;
  logic                        p1;
  logic                        p1_mask;
  logic                        p2;

  logic [SAMPLE_WIDTH-1:0]     hist_mem [TAPS];
  logic [COEFF_WIDTH-1:0]      tap_mem  [TAPS];
  logic [SAMPLE_WIDTH-1:0]     hist_q;
  logic [COEFF_WIDTH-1:0]      tap_q;
  logic signed [PW-1:0]        prod;
  logic signed [ACC_WIDTH-1:0] acc;

  logic [TAP_COUNT_WIDTH:0]    tc_ext;
  logic [LW-1:0]               l_eff;
  logic                        sample_acc;
  logic                        load_acc;
  logic                        adv;
  logic [AW-1:0]               head_inc;
  logic [SAMPLE_WIDTH-1:0]     hist_wdata;
  logic                        issue;
  logic                        mac_done;
  logic signed [ACC_WIDTH-1:0] rnd;
  logic signed [ACC_WIDTH-1:0] shifted;
  logic                        sat_hi;
  logic                        sat_lo;
  logic [SAMPLE_WIDTH-1:0]     y_val;
  logic                        emit;
  logic                        step_done;
  logic                        final_pass;
  logic                        more;
  logic                        load_out;

  always_comb begin
    tc_ext = {1'b0, tap_count};
    if (tap_count == '0) begin
      l_eff = LW'(1);
    end else if (tc_ext > TAPS_C) begin
      l_eff = TAPS_L;
    end else begin
      l_eff = LW'(tc_ext);
    end
  end

  assign in_ready   = (state == ST_IDLE);
  assign sample_acc = in_valid && in_ready && (in_data.opcode == OP_SAMPLE);
  assign load_acc   = in_valid && in_ready && (in_data.opcode == OP_LOAD);
  assign head_inc   = (head == LAST_ADDR) ? '0 : head + AW'(1);
  assign hist_wdata = sample_acc ? in_data.sample_value : '0;

  assign issue    = (state == ST_MAC) && (mac_cnt < l_eff);
  assign mac_done = (state == ST_MAC) && !issue && !p1 && !p2;

  assign rnd     = acc + ROUND_BIAS;
  assign shifted = rnd >>> ROUND_SHIFT;
  assign sat_hi  = shifted > SAT_HI;
  assign sat_lo  = shifted < SAT_LO;
  assign y_val   = sat_hi ? SAT_HI[SAMPLE_WIDTH-1:0] :
                   sat_lo ? SAT_LO[SAMPLE_WIDTH-1:0] : shifted[SAMPLE_WIDTH-1:0];

  assign emit       = (out_count >= l_eff);
  assign step_done  = (state == ST_FINISH) && (!emit || !out_valid || out_ready);
  assign final_pass = last_q && (flush_cnt == l_eff - LW'(1));
  assign more       = last_q && !final_pass;
  assign load_out   = step_done && emit;
  assign adv        = sample_acc || (step_done && more);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tap_count <= TAP_COUNT_RESET;
      head      <= '0;
      rd_ptr    <= '0;
      fill      <= '0;
      mac_cnt   <= '0;
      flush_cnt <= '0;
      out_count <= '0;
      last_q    <= 1'b0;
      p1        <= 1'b0;
      p1_mask   <= 1'b0;
      p2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tap_count <= cfg_wr_data;
      end

      p1      <= issue;
      p1_mask <= (mac_cnt < fill);
      p2      <= p1;

      if (issue) begin
        mac_cnt <= mac_cnt + LW'(1);
        rd_ptr  <= (rd_ptr == '0) ? LAST_ADDR : rd_ptr - AW'(1);
      end

      if (sample_acc) begin
        last_q    <= in_data.last_sample;
        flush_cnt <= '0;
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (sample_acc) begin
            state <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (mac_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (step_done) begin
            if (more) begin
              if (!emit) begin
                out_count <= out_count + LW'(1);
              end
              flush_cnt <= flush_cnt + LW'(1);
              state     <= ST_MAC;
            end else begin
              if (last_q) begin
                fill      <= '0;
                out_count <= '0;
              end else if (!emit) begin
                out_count <= out_count + LW'(1);
              end
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // advance the delay line; takes priority over the end-of-stream clear
      if (adv) begin
        head    <= head_inc;
        rd_ptr  <= head_inc;
        mac_cnt <= '0;
        fill    <= (fill == TAPS_L) ? fill : fill + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hist_mem[head_inc] <= hist_wdata;
    end
    hist_q <= hist_mem[rd_ptr];

    if (load_acc && ({{(TAP_COUNT_WIDTH + 1 - INDEX_WIDTH){1'b0}}, in_data.coeff_index} < TAPS_C))
    begin
      tap_mem[AW'(in_data.coeff_index)] <= in_data.coeff_value;
    end
    tap_q <= tap_mem[mac_cnt[AW-1:0]];

    if (p1_mask) begin
      prod <= $signed(hist_q) * $signed(tap_q);
    end else begin
      prod <= '0;
    end

    if (adv) begin
      acc <= '0;
    end else if (p2) begin
      acc <= acc + {{(ACC_WIDTH - PW){prod[PW-1]}}, prod};
    end

    if (load_out) begin
      out_data.filtered_sample <= y_val;
      out_data.saturated       <= sat_hi || sat_lo;
      out_data.final_result    <= final_pass;
    end
  end

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !p1 && !p2)
    else $error("multiply pipeline busy while idle");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAC) |-> mac_cnt <= l_eff)
    else $error("tap walk ran past the active tap count");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= TAPS_L)
    else $error("fill count beyond delay line depth");

  a_stream_clear: assert property (@(posedge clk) disable iff (rst)
    step_done && !more && last_q |=> fill == '0 && out_count == '0 && state == ST_IDLE)
    else $error("stream not cleared after final pass");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result raised outside the rounding step");

endmodule
